@@ hdl/wss_pkg.sv @@
// ----------------------------------------------------------------------------
// Winding-stairs sensitivity package
// Shared types and fixed constants for the sensitivity estimator.
// ----------------------------------------------------------------------------
package wss_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned RATIO_W  = 32;
    localparam int unsigned ACC_W    = 64;
    localparam int unsigned CNT_W    = 10;
    localparam int unsigned FRAC_BITS = 28;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FAILED   = 2'd1;
    localparam logic [1:0] ST_ZERO_VAR = 2'd2;

    localparam logic [1:0] CFG_NUM_FACTORS = 2'd0;
    localparam logic [1:0] CFG_REPEATS     = 2'd1;
    localparam logic [1:0] CFG_MIN_VALID   = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       sample_ok;
    } t_in_word;

    typedef struct packed {
        logic [3:0]                 factor_number;
        logic signed [RATIO_W-1:0]  first_order;
        logic signed [RATIO_W-1:0]  total_effect;
        logic [1:0]                 status;
        logic                       last;
    } t_out_word;

    // Saturating unsigned add.
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

endpackage

@@ hdl/wss_stream_if.sv @@
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one word of type T with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface wss_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/wss_divider.sv @@
// ----------------------------------------------------------------------------
// Sequential divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wss_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wss_pkg::ACC_W-1:0] i_num,
    input  logic [wss_pkg::ACC_W-1:0] i_den,
    output logic                      o_done,
    output logic [wss_pkg::ACC_W-1:0] o_quot,
    output logic [wss_pkg::ACC_W-1:0] o_rem
);
    localparam int unsigned W = wss_pkg::ACC_W;

    logic [W-1:0]         r_num, r_den, r_quot;
    logic [W:0]           r_rem;
    logic [6:0]           r_cnt;
    logic                 r_busy, r_done;
    logic [W:0]           n_shift;
    logic                 n_ge;

    assign n_shift = {r_rem[W-1:0], r_num[W-1]};
    assign n_ge    = n_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(W);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_num  <= {r_num[W-2:0], 1'b0};
                r_rem  <= n_ge ? n_shift - {1'b0, r_den} : n_shift;
                r_quot <= {r_quot[W-2:0], n_ge};
                r_cnt  <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[W-1:0];
endmodule

@@ hdl/winding_stairs_sensitivity.sv @@
// ----------------------------------------------------------------------------
// Winding-stairs sensitivity estimator
// Loads one output column into a sample memory, then walks it per factor and
// emits first-order and total-effect indices, or one failed/zero-variance word.
// ----------------------------------------------------------------------------
// Load: one word per cycle (single write port) while no result word is pending.
// Compute: per factor, up to three registered reads per row and up to four
//   divisions; then one division by the factor count and, per factor, two
//   divisions, each followed by a 28-bit fraction.
// Reset (synchronous, active low) restores the default registers and an empty
//   column; the sample memory keeps its contents and needs no clearing.
module winding_stairs_sensitivity #(
    parameter int unsigned MAX_FACTORS = 16,
    parameter int unsigned MAX_SAMPLES = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    wss_stream_if.sink   s_in,
    wss_stream_if.source m_out
);
    localparam int unsigned AW = $clog2(MAX_SAMPLES);
    localparam int unsigned NW = AW + 1;
    localparam int unsigned FW = $clog2(MAX_FACTORS);
    localparam int unsigned W  = wss_pkg::ACC_W;
    localparam int unsigned CW = wss_pkg::CNT_W;

    typedef enum logic [13:0] {
        S_LOAD  = 14'b00000000000001,
        S_FINIT = 14'b00000000000010,
        S_RD_B  = 14'b00000000000100,
        S_RD_N  = 14'b00000000001000,
        S_RD_P  = 14'b00000000010000,
        S_ACC   = 14'b00000000100000,
        S_MEAN  = 14'b00000001000000,
        S_MSQ   = 14'b00000010000000,
        S_DI    = 14'b00000100000000,
        S_DTI   = 14'b00001000000000,
        S_DD    = 14'b00010000000000,
        S_QF    = 14'b00100000000000,
        S_QT    = 14'b01000000000000,
        S_EMIT  = 14'b10000000000000
    } t_state;

    t_state r_state;

    logic [4:0] r_nf;
    logic [8:0] r_rep;
    logic [9:0] r_minv;

    // Effective factor count and column length.
    logic [FW:0]  k_eff;
    logic [9:0]   r_eff;
    logic [19:0]  n_raw;
    logic [NW-1:0] n_len;

    always_comb begin
        if (r_nf < 5'd2) k_eff = (FW+1)'(2);
        else if (32'(r_nf) > MAX_FACTORS) k_eff = (FW+1)'(MAX_FACTORS);
        else k_eff = (FW+1)'(r_nf);
        r_eff = (r_rep == 9'd0) ? 10'd2 : 10'(r_rep) + 10'd1;
        n_raw = 20'(k_eff) * 20'(r_eff);
        n_len = (n_raw > 20'(MAX_SAMPLES)) ? NW'(MAX_SAMPLES) : NW'(n_raw);
    end

    // Sample memory.
    logic [32:0]   mem [MAX_SAMPLES];
    logic [32:0]   r_rdata;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= {s_in.data.sample_ok, s_in.data.sample_value};
        r_rdata <= mem[rd_addr];
    end

    logic [NW-1:0] r_load;
    logic [NW-1:0] r_b;
    logic [FW-1:0] r_f;
    logic          r_fail;

    logic signed [W-1:0] r_sum;
    logic [W-1:0]  r_sq, r_fd, r_td, r_var, r_msq, r_d;
    logic [CW-1:0] r_c0, r_c1, r_c2;
    logic signed [32:0] r_v;
    logic [W-1:0]  di_mem [MAX_FACTORS];
    logic [W-1:0]  dt_mem [MAX_FACTORS];
    logic [W-1:0]  r_qf;
    logic          r_frac;
    logic [W-1:0]  r_fnum, r_fden, r_frem;
    logic [31:0]   r_fq;
    logic [4:0]    r_fstep;
    logic          r_qsel;
    logic          r_dsub;

    logic [W-1:0]  n_num, n_den;
    logic          n_start;
    logic          div_done;
    logic [W-1:0]  div_q, div_r;
    logic          r_sign;

    wss_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_start),
        .i_num   (n_num),
        .i_den   (n_den),
        .o_done  (div_done),
        .o_quot  (div_q),
        .o_rem   (div_r)
    );

    wss_pkg::t_out_word r_out;
    logic               r_ovalid;

    assign s_in.ready  = (r_state == S_LOAD) && !r_ovalid;
    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_out;

    logic in_fire;
    assign in_fire = s_in.valid && s_in.ready;
    assign wr_en   = in_fire && (r_load < NW'(MAX_SAMPLES));
    assign wr_addr = r_load[AW-1:0];

    logic [NW-1:0] n_nx;
    assign n_nx = r_b + NW'(k_eff) - NW'(1);

    always_comb begin
        case (r_state)
            S_RD_N:  rd_addr = n_nx[AW-1:0];
            S_RD_P:  rd_addr = AW'(r_b - NW'(1));
            default: rd_addr = r_b[AW-1:0];
        endcase
    end

    logic [32:0] n_diff;
    logic [32:0] n_adiff;
    logic [W-1:0] n_sqd;
    assign n_diff  = r_v - 33'(signed'(r_rdata[31:0]));
    assign n_adiff = n_diff[32] ? -n_diff : n_diff;
    assign n_sqd   = W'(n_adiff) * W'(n_adiff);

    logic [W-1:0] n_vsq;
    logic [32:0]  n_av;
    assign n_av  = r_v[32] ? -r_v : r_v;
    assign n_vsq = W'(n_av) * W'(n_av);

    logic [W-1:0] n_abs_sum;
    assign n_abs_sum = r_sum[W-1] ? -r_sum : r_sum;

    logic [W-1:0] n_mm;
    logic [31:0]  n_m32;
    assign n_m32 = div_q[31:0];
    assign n_mm  = W'(n_m32) * W'(n_m32);

    logic [W:0] n_twice;
    assign n_twice = {r_frem, 1'b0};

    always_comb begin
        n_start = 1'b0;
        n_num   = '0;
        n_den   = '0;
        case (r_state)
            S_ACC: begin
                n_num = n_abs_sum;
                n_den = W'(r_c0);
            end
            S_MEAN: begin
                n_num = r_sq;
                n_den = W'(r_c0);
            end
            S_MSQ: begin
                n_num = r_fd;
                n_den = W'({r_c1, 1'b0});
            end
            S_DI: begin
                n_num = r_td;
                n_den = W'({r_c2, 1'b0});
            end
            S_DD: begin
                n_num = r_var;
                n_den = W'(k_eff);
            end
            default: begin
                n_num = r_qsel ? dt_mem[r_f] : di_mem[r_f];
                n_den = r_d;
            end
        endcase
        n_start = r_dsub;
    end

    logic r_vsel;
    logic n_rows_done;
    assign n_rows_done = (r_b >= n_len) || (r_b >= NW'(20'(k_eff) * 20'(r_eff)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_nf     <= 5'd2;
            r_rep    <= 9'd500;
            r_minv   <= 10'd500;
            r_load   <= '0;
            r_ovalid <= 1'b0;
            r_dsub   <= 1'b0;
            r_frac   <= 1'b0;
            r_vsel   <= 1'b0;
        end else begin
            r_dsub <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wss_pkg::CFG_NUM_FACTORS: r_nf   <= i_cfg_data[4:0];
                    wss_pkg::CFG_REPEATS:     r_rep  <= i_cfg_data[8:0];
                    wss_pkg::CFG_MIN_VALID:   r_minv <= i_cfg_data;
                    default: ;
                endcase
            end
            if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (in_fire) begin
                        if (r_load + NW'(1) >= n_len) begin
                            r_load  <= '0;
                            r_f     <= '0;
                            r_fail  <= 1'b0;
                            r_var   <= '0;
                            r_state <= S_FINIT;
                        end else begin
                            r_load <= r_load + NW'(1);
                        end
                    end
                end
                S_FINIT: begin
                    r_sum <= '0;
                    r_sq  <= '0;
                    r_fd  <= '0;
                    r_td  <= '0;
                    r_c0  <= '0;
                    r_c1  <= '0;
                    r_c2  <= '0;
                    r_b   <= NW'(r_f);
                    r_vsel <= 1'b0;
                    r_state <= S_RD_B;
                end
                S_RD_B: begin
                    // Address b issued; data arrives next cycle.
                    if (n_rows_done) begin
                        r_dsub  <= (r_c0 != '0);
                        r_state <= S_ACC;
                    end else if (!r_vsel) begin
                        r_vsel <= 1'b1;
                    end else begin
                        r_vsel <= 1'b0;
                        r_v    <= 33'(signed'(r_rdata[31:0]));
                        if (r_rdata[32]) begin
                            r_c0  <= r_c0 + CW'(1);
                            r_sum <= r_sum + W'(signed'(r_rdata[31:0]));
                            r_state <= S_RD_N;
                        end else begin
                            r_b <= r_b + NW'(k_eff);
                        end
                    end
                end
                S_RD_N: begin
                    if (!r_vsel) begin
                        // The square of the row's own sample is added while the
                        // next-row read is in flight.
                        r_vsel <= 1'b1;
                        r_sq   <= wss_pkg::sat_add(r_sq, n_vsq);
                    end else begin
                        r_vsel <= 1'b0;
                        if (n_nx < n_len && r_rdata[32]) begin
                            r_c1 <= r_c1 + CW'(1);
                            r_fd <= wss_pkg::sat_add(r_fd, n_sqd);
                        end
                        r_state <= S_RD_P;
                    end
                end
                S_RD_P: begin
                    if (!r_vsel) begin
                        r_vsel <= 1'b1;
                    end else begin
                        r_vsel <= 1'b0;
                        if (r_b != '0 && r_rdata[32]) begin
                            r_c2 <= r_c2 + CW'(1);
                            r_td <= wss_pkg::sat_add(r_td, n_sqd);
                        end
                        r_b     <= r_b + NW'(k_eff);
                        r_state <= S_RD_B;
                    end
                end
                S_ACC: begin
                    if (r_c0 == '0) begin
                        r_state <= S_MEAN;
                        r_dsub  <= 1'b0;
                        r_msq   <= '0;
                        r_sign  <= 1'b0;
                    end else if (div_done) begin
                        r_msq   <= n_mm;
                        r_dsub  <= 1'b1;
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (r_c0 == '0) begin
                        r_dsub  <= (r_c1 != '0);
                        r_state <= S_MSQ;
                    end else if (div_done) begin
                        r_var <= wss_pkg::sat_add(r_var,
                                 (div_q > r_msq) ? div_q - r_msq : '0);
                        r_dsub  <= (r_c1 != '0);
                        r_state <= S_MSQ;
                    end
                end
                S_MSQ: begin
                    if (r_c1 == '0) begin
                        di_mem[r_f] <= '0;
                        r_dsub  <= (r_c2 != '0);
                        r_state <= S_DI;
                    end else if (div_done) begin
                        di_mem[r_f] <= div_q;
                        r_dsub  <= (r_c2 != '0);
                        r_state <= S_DI;
                    end
                end
                S_DI: begin
                    if (r_c2 == '0 || div_done) begin
                        dt_mem[r_f] <= (r_c2 == '0) ? '0 : div_q;
                        if (r_c0 < r_minv || r_c1 < r_minv || r_c2 < r_minv)
                            r_fail <= 1'b1;
                        if (32'(r_f) + 1 >= 32'(k_eff)) begin
                            r_state <= S_DTI;
                        end else begin
                            r_f     <= r_f + FW'(1);
                            r_state <= S_FINIT;
                        end
                    end
                end
                S_DTI: begin
                    if (!r_ovalid) begin
                        if (r_fail) begin
                            r_out    <= '{4'd0, '0, '0, wss_pkg::ST_FAILED, 1'b1};
                            r_ovalid <= 1'b1;
                            r_state  <= S_LOAD;
                        end else begin
                            r_dsub  <= 1'b1;
                            r_state <= S_DD;
                        end
                    end
                end
                S_DD: begin
                    if (div_done) begin
                        r_d <= div_q;
                        if (div_q == '0) begin
                            r_out    <= '{4'd0, '0, '0, wss_pkg::ST_ZERO_VAR, 1'b1};
                            r_ovalid <= 1'b1;
                            r_state  <= S_LOAD;
                        end else begin
                            r_f     <= '0;
                            r_qsel  <= 1'b0;
                            r_dsub  <= 1'b1;
                            r_state <= S_QF;
                        end
                    end
                end
                S_QF, S_QT: begin
                    if (div_done) begin
                        r_frac  <= 1'b1;
                        r_fden  <= r_d;
                        r_frem  <= div_r;
                        r_fq    <= (div_q >= W'(16)) ? 32'd0 : 32'(div_q);
                        r_fstep <= (div_q >= W'(16)) ? 5'd0 : 5'(wss_pkg::FRAC_BITS);
                        r_fnum  <= (div_q >= W'(16)) ? W'(1) : W'(0);
                    end else if (r_frac) begin
                        if (r_fstep != 5'd0) begin
                            r_fstep <= r_fstep - 5'd1;
                            if (n_twice >= {1'b0, r_fden}) begin
                                r_frem <= W'(n_twice - {1'b0, r_fden});
                                r_fq   <= {r_fq[30:0], 1'b1};
                            end else begin
                                r_frem <= W'(n_twice);
                                r_fq   <= {r_fq[30:0], 1'b0};
                            end
                        end else begin
                            r_frac <= 1'b0;
                            if (!r_qsel) begin
                                // Overflow flag rides in the low bit of r_fnum.
                                r_qf    <= {31'd0, r_fnum[0], r_fq};
                                r_qsel  <= 1'b1;
                                r_dsub  <= 1'b1;
                                r_state <= S_QT;
                            end else begin
                                r_qsel  <= 1'b0;
                                r_sign  <= r_fnum[0];
                                r_state <= S_EMIT;
                            end
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid) begin
                        logic signed [W-1:0] fo;
                        fo = W'(1 << wss_pkg::FRAC_BITS) - r_qf;
                        r_out.factor_number <= 4'(r_f);
                        r_out.first_order   <= (fo < -W'(64'sh80000000))
                                               ? 32'sh80000000 : fo[31:0];
                        r_out.total_effect  <= (r_sign || r_fq[31])
                                               ? 32'sh7FFFFFFF : r_fq;
                        r_out.status        <= wss_pkg::ST_OK;
                        r_out.last          <= (32'(r_f) + 1 >= 32'(k_eff));
                        r_ovalid            <= 1'b1;
                        if (32'(r_f) + 1 >= 32'(k_eff)) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_f     <= r_f + FW'(1);
                            r_dsub  <= 1'b1;
                            r_state <= S_QF;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule

@@ hdl/wss_checker.sv @@
// ----------------------------------------------------------------------------
// Port checker
// Watches the ports of the estimator over time.
// ----------------------------------------------------------------------------
module wss_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] out_status,
    input logic out_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_status != wss_pkg::ST_OK |-> out_last)
        else $error("failure result not marked last");

    a_no_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a result is pending");

    a_start: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result after reset");
endmodule

bind winding_stairs_sensitivity wss_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (s_in.valid),
    .in_ready   (s_in.ready),
    .out_valid  (m_out.valid),
    .out_ready  (m_out.ready),
    .out_status (m_out.data.status),
    .out_last   (m_out.data.last)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Winding-stairs sensitivity testbench
// Loads sample columns under many register settings, predicts the per-factor
// first-order and total-effect indices for each column and checks every
// result word that the estimator emits, in order, field by field.
// ----------------------------------------------------------------------------

class SensitivityScoreboard;
    localparam int unsigned DEPTH = 8192;
    localparam int unsigned FACTOR_CAP = 16;

    wss_pkg::t_out_word expected_q[$];
    logic [32:0] samples[DEPTH];
    int unsigned fill;
    int unsigned k_reg, r_reg, min_reg;
    int          errors;
    int          words_checked;
    int          columns_done;

    function new();
        fill = 0;
        k_reg = 2;
        r_reg = 500;
        min_reg = 500;
        errors = 0;
        words_checked = 0;
        columns_done = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [9:0] value);
        case (idx)
            wss_pkg::CFG_NUM_FACTORS: k_reg = value[4:0];
            wss_pkg::CFG_REPEATS:     r_reg = value[8:0];
            wss_pkg::CFG_MIN_VALID:   min_reg = value;
            default: ;
        endcase
    endfunction

    function int unsigned factors();
        if (k_reg < 2) return 2;
        if (k_reg > FACTOR_CAP) return FACTOR_CAP;
        return k_reg;
    endfunction

    function int unsigned rounds();
        return (r_reg == 0) ? 1 : r_reg;
    endfunction

    function int unsigned column_length();
        int unsigned n;
        n = factors() * (rounds() + 1);
        return (n > DEPTH) ? DEPTH : n;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function longint unsigned add_clip(longint unsigned a, longint unsigned b);
        return (a > 64'hFFFF_FFFF_FFFF_FFFF - b) ? 64'hFFFF_FFFF_FFFF_FFFF : a + b;
    endfunction

    function longint signed value_at(int unsigned idx);
        return longint'($signed(samples[idx][31:0]));
    endfunction

    function longint unsigned diff_square(longint signed a, longint signed b);
        longint signed d;
        longint unsigned u;
        d = a - b;
        u = (d < 0) ? -d : d;
        return u * u;
    endfunction

    // Fixed-point quotient with 28 fraction bits, capped at 2^32.
    function longint unsigned fraction_q28(longint unsigned num, longint unsigned den);
        longint unsigned whole, rem, q;
        whole = num / den;
        rem = num % den;
        if (whole >= 16) return 64'h1_0000_0000;
        q = whole;
        for (int b = 0; b < 28; b++) begin
            q = q << 1;
            if (rem >= den - rem) begin
                rem = rem - (den - rem);
                q = q | 1;
            end else begin
                rem = rem << 1;
            end
        end
        return q;
    endfunction

    function void push_word(int unsigned f, longint signed fo, longint signed te,
                            logic [1:0] st, bit fin);
        wss_pkg::t_out_word w;
        w.factor_number = f[3:0];
        w.first_order = fo[31:0];
        w.total_effect = te[31:0];
        w.status = st;
        w.last = fin;
        expected_q.push_back(w);
    endfunction

    function void estimate_column(int unsigned k, int unsigned r, int unsigned n);
        longint unsigned var_sum, sq, c0, c1, c2, msq, mm, d, qf, qt;
        longint unsigned first_d[FACTOR_CAP];
        longint unsigned total_d[FACTOR_CAP];
        longint signed sum, v, m, fo, te;
        int unsigned b, nx;
        bit fail;
        var_sum = 0;
        fail = 0;
        columns_done++;
        for (int unsigned i = 0; i < k; i++) begin
            c0 = 0; c1 = 0; c2 = 0; sum = 0; sq = 0;
            first_d[i] = 0;
            total_d[i] = 0;
            for (int unsigned row = 0; row <= r; row++) begin
                b = row * k + i;
                nx = b + k - 1;
                if (b >= n || !samples[b][32]) continue;
                v = value_at(b);
                c0++;
                sum += v;
                sq = add_clip(sq, longint'(v * v));
                if (nx < n && samples[nx][32]) begin
                    c1++;
                    first_d[i] = add_clip(first_d[i], diff_square(v, value_at(nx)));
                end
                if (b >= 1 && samples[b-1][32]) begin
                    c2++;
                    total_d[i] = add_clip(total_d[i], diff_square(v, value_at(b - 1)));
                end
            end
            if (c0 < min_reg || c1 < min_reg || c2 < min_reg) fail = 1;
            if (c0 > 0) begin
                m = sum / longint'(c0);
                mm = m * m;
                msq = sq / c0;
                var_sum = add_clip(var_sum, (msq > mm) ? msq - mm : 0);
            end
            first_d[i] = (c1 != 0) ? first_d[i] / (2 * c1) : 0;
            total_d[i] = (c2 != 0) ? total_d[i] / (2 * c2) : 0;
        end
        if (fail) begin
            push_word(0, 0, 0, wss_pkg::ST_FAILED, 1);
            return;
        end
        d = var_sum / k;
        if (d == 0) begin
            push_word(0, 0, 0, wss_pkg::ST_ZERO_VAR, 1);
            return;
        end
        for (int unsigned i = 0; i < k; i++) begin
            qf = fraction_q28(first_d[i], d);
            qt = fraction_q28(total_d[i], d);
            fo = longint'(64'd1 << 28) - longint'(qf);
            te = (qt > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : longint'(qt);
            if (fo < -64'sd2147483648) fo = -64'sd2147483648;
            push_word(i, fo, te, wss_pkg::ST_OK, (i + 1 == k));
        end
    endfunction

    function void note_sample(wss_pkg::t_in_word w);
        int unsigned n;
        n = column_length();
        if (fill < DEPTH) samples[fill] = {w.sample_ok, w.sample_value};
        fill++;
        if (fill >= n) begin
            fill = 0;
            estimate_column(factors(), rounds(), n);
        end
    endfunction

    function void check_word(wss_pkg::t_out_word got);
        wss_pkg::t_out_word want;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        words_checked++;
        if (got.factor_number !== want.factor_number) begin
            $display("%0t: factor_number expected %0d actual %0d",
                     $time, want.factor_number, got.factor_number);
            errors++;
        end
        if (got.first_order !== want.first_order) begin
            $display("%0t: first_order expected %h actual %h",
                     $time, want.first_order, got.first_order);
            errors++;
        end
        if (got.total_effect !== want.total_effect) begin
            $display("%0t: total_effect expected %h actual %h",
                     $time, want.total_effect, got.total_effect);
            errors++;
        end
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
        end
        if (got.last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int STUCK_LIMIT = 100000;
    localparam int HOLD_CYCLES = 600;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [9:0] i_cfg_data;

    wss_stream_if #(.T(wss_pkg::t_in_word))  in_if ();
    wss_stream_if #(.T(wss_pkg::t_out_word)) out_if ();

    winding_stairs_sensitivity DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_in        (in_if),
        .m_out       (out_if)
    );

    SensitivityScoreboard sb = new();

    bit quiet = 0;
    bit hold_req = 0;
    int items_sent = 0;
    int stuck = 0;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: counts cycles in which neither side moves a word.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
            if (stuck >= STUCK_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Result receiver with random stalls and one long hold-off on request.
    initial begin
        int stall;
        out_if.ready <= 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                out_if.ready <= 0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 0;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, 18);
                if (stall > 0) begin
                    out_if.ready <= 0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_if.ready <= 1;
            do @(posedge i_clk); while (!out_if.valid);
            sb.check_word(out_if.data);
        end
    end

    task automatic program_regs(int k, int r, int m);
        i_cfg_we <= 1;
        i_cfg_index <= wss_pkg::CFG_NUM_FACTORS;
        i_cfg_data <= k[9:0];
        sb.set_reg(wss_pkg::CFG_NUM_FACTORS, k[9:0]);
        @(posedge i_clk);
        i_cfg_index <= wss_pkg::CFG_REPEATS;
        i_cfg_data <= r[9:0];
        sb.set_reg(wss_pkg::CFG_REPEATS, r[9:0]);
        @(posedge i_clk);
        i_cfg_index <= wss_pkg::CFG_MIN_VALID;
        i_cfg_data <= m[9:0];
        sb.set_reg(wss_pkg::CFG_MIN_VALID, m[9:0]);
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    // Valid is only lowered when a gap follows, so it never toggles within a step.
    task automatic send_word(logic [31:0] value, bit ok);
        wss_pkg::t_in_word w;
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            in_if.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        w.sample_value = value;
        w.sample_ok = ok;
        in_if.valid <= 1;
        in_if.data <= w;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_sample(w);
        items_sent++;
    endtask

    task automatic settle();
        in_if.valid <= 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic send_column(int style, int bad);
        int n;
        logic [31:0] base, value;
        n = sb.column_length();
        base = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 65535);
        for (int j = 0; j < n; j++) begin
            case (style)
                0: value = $urandom;
                1: value = base + $urandom_range(0, 4095) - 2048;
                2: value = base;
                default: value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            endcase
            send_word(value, $urandom_range(0, 7) >= bad);
        end
    endtask

    initial begin
        int k, r, m, cols;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = wss_pkg::CFG_NUM_FACTORS;
        i_cfg_data = 0;
        in_if.valid = 0;
        in_if.data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Extreme values; repeats of zero behaves as one.
        program_regs(2, 0, 0);
        send_word(32'h7FFF_FFFF, 1);
        send_word(32'h8000_0000, 1);
        send_word(32'h0000_0000, 1);
        send_word(32'hFFFF_FFFF, 1);
        settle();
        // All samples equal: zero variance.
        send_word(32'h0001_2345, 1);
        send_word(32'h0001_2345, 1);
        send_word(32'h0001_2345, 1);
        send_word(32'h0001_2345, 1);
        settle();
        // One failed run leaves a factor short of valid pairs.
        program_regs(1, 1, 1);
        send_word(32'h0003_0000, 1);
        send_word(32'h0001_0000, 0);
        send_word(32'hFFFE_0000, 1);
        send_word(32'h0005_8000, 1);
        settle();
        // Column shortened while loading: the next word completes it.
        program_regs(3, 3, 0);
        for (int j = 0; j < 7; j++) send_word($urandom, 1);
        settle();
        program_regs(3, 1, 0);
        send_word($urandom, 1);
        settle();

        cols = 0;
        while (items_sent < 290) begin
            k = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(2, 5);
            r = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 5);
            if (k > 8) r = $urandom_range(0, 1);
            m = $urandom_range(0, 15) == 0 ? 512 : $urandom_range(0, 3);
            program_regs(k, r, m);
            quiet = ($urandom_range(0, 3) == 0);
            // The second multi-column phase gets the long receiver hold-off.
            if (cols == 1) hold_req = 1;
            repeat ($urandom_range(1, 3)) begin
                send_column($urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 3),
                            $urandom_range(0, 2) == 0 ? $urandom_range(1, 4) : 0);
            end
            cols++;
            settle();
        end

        // Factor count written as out-of-range values, low and high.
        quiet = 1;
        program_regs(0, 3, 0);
        send_column(0, 0);
        settle();
        program_regs(31, 1, 1023);
        send_column(0, 0);
        settle();
        repeat (50) @(posedge i_clk);

        $display("Sent %0d samples in %0d columns; checked %0d result words.",
                 items_sent, sb.columns_done, sb.words_checked);
        $display("Mismatches found: %0d.", sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/wss_pkg.sv
hdl/wss_stream_if.sv
hdl/wss_divider.sv
hdl/winding_stairs_sensitivity.sv
hdl/wss_checker.sv
tb/sv/testbench.sv
